>>> src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] ERR_UNTERM_STR  = 4'd0;
  localparam logic [3:0] ERR_CTRL_CHAR   = 4'd1;
  localparam logic [3:0] ERR_UNTERM_ESC  = 4'd2;
  localparam logic [3:0] ERR_UNKNOWN_ESC = 4'd3;
  localparam logic [3:0] ERR_TRUNC_HEX   = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX     = 4'd5;
  localparam logic [3:0] ERR_HIGH_ALONE  = 4'd6;
  localparam logic [3:0] ERR_HIGH_NO_LOW = 4'd7;
  localparam logic [3:0] ERR_LONE_LOW    = 4'd8;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_BODY = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_HBS  = 3'd4,
    MODE_HU   = 3'd5
  } mode_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0]      last_idx;
    logic [1:0]      kind;
    logic [3:0]      code;
    logic [3:0][7:0] bytes;
  } rset_t;

endpackage

>>> src/jsu_in_buf.sv
// ----------------------------------------------------------------------------
// jsu_in_buf
// Two-entry input buffer; stall comes straight from the fill count.
// ----------------------------------------------------------------------------
module jsu_in_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid,
  output logic           stall,
  input  jsu_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_take,
  output jsu_pkg::item_t rd_item
);

  jsu_pkg::item_t ent [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign stall    = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = ent[rd_ptr];
  assign push     = valid && !stall;
  assign pop      = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> src/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape and surrogate state machine with UTF-8 encoding of each code point.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  jsu_pkg::item_t item,
  output logic           set_valid,
  output jsu_pkg::rset_t set
);

  jsu_pkg::mode_t mode;
  jsu_pkg::mode_t mode_next;
  logic [1:0]     hex_count;
  logic [1:0]     hex_count_next;
  logic [15:0]    hex_accum;
  logic [15:0]    hex_accum_next;
  logic [9:0]     high_part;
  logic [9:0]     high_part_next;
  logic           in_low_unit;
  logic           in_low_unit_next;

  logic [7:0]      c;
  logic [3:0]      hv;
  logic            hok;
  logic [15:0]     acc_new;
  logic            unit_end;
  logic            is_high;
  logic            is_low;
  logic [20:0]     cp;
  logic [3:0][7:0] enc_bytes;
  logic [1:0]      enc_last;

  assign c = item.data;

  always_comb begin
    hv  = 4'd0;
    hok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) begin
      hv = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hv = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hv = 4'(c - 8'h37);
    end else begin
      hok = 1'b0;
    end
  end

  assign acc_new  = {hex_accum[11:0], hv};
  assign unit_end = hok && (hex_count == 2'd3);
  assign is_high  = (acc_new[15:10] == 6'b110110);
  assign is_low   = (acc_new[15:10] == 6'b110111);
  assign cp       = in_low_unit ? (21'h10000 + {1'b0, high_part, acc_new[9:0]})
                                : {5'd0, acc_new};

  always_comb begin
    enc_bytes = '0;
    if (cp < 21'h80) begin
      enc_bytes[0] = cp[7:0];
      enc_last     = 2'd0;
    end else if (cp < 21'h800) begin
      enc_bytes[0] = {3'b110, cp[10:6]};
      enc_bytes[1] = {2'b10, cp[5:0]};
      enc_last     = 2'd1;
    end else if (cp < 21'h10000) begin
      enc_bytes[0] = {4'b1110, cp[15:12]};
      enc_bytes[1] = {2'b10, cp[11:6]};
      enc_bytes[2] = {2'b10, cp[5:0]};
      enc_last     = 2'd2;
    end else begin
      enc_bytes[0] = {5'b11110, cp[20:18]};
      enc_bytes[1] = {2'b10, cp[17:12]};
      enc_bytes[2] = {2'b10, cp[11:6]};
      enc_bytes[3] = {2'b10, cp[5:0]};
      enc_last     = 2'd3;
    end
  end

  // next state
  always_comb begin
    mode_next        = mode;
    hex_count_next   = hex_count;
    hex_accum_next   = hex_accum;
    high_part_next   = high_part;
    in_low_unit_next = in_low_unit;
    unique case (item.cmd)
      jsu_pkg::CMD_START: begin
        mode_next        = jsu_pkg::MODE_BODY;
        hex_count_next   = 2'd0;
        hex_accum_next   = 16'd0;
        high_part_next   = 10'd0;
        in_low_unit_next = 1'b0;
      end
      jsu_pkg::CMD_DATA: begin
        unique case (mode)
          jsu_pkg::MODE_BODY: begin
            if (c == 8'h22 || c < 8'h20) begin
              mode_next = jsu_pkg::MODE_IDLE;
            end else if (c == 8'h5C) begin
              mode_next = jsu_pkg::MODE_ESC;
            end
          end
          jsu_pkg::MODE_ESC: begin
            unique case (c)
              8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74: begin
                mode_next = jsu_pkg::MODE_BODY;
              end
              8'h75: begin
                mode_next        = jsu_pkg::MODE_HEX;
                hex_count_next   = 2'd0;
                hex_accum_next   = 16'd0;
                in_low_unit_next = 1'b0;
              end
              default: begin
                mode_next = jsu_pkg::MODE_IDLE;
              end
            endcase
          end
          jsu_pkg::MODE_HEX: begin
            if (!hok) begin
              mode_next = jsu_pkg::MODE_IDLE;
            end else begin
              hex_accum_next = acc_new;
              hex_count_next = hex_count + 2'd1;
              if (unit_end) begin
                if (in_low_unit) begin
                  mode_next = is_low ? jsu_pkg::MODE_BODY : jsu_pkg::MODE_IDLE;
                end else if (is_high) begin
                  high_part_next = acc_new[9:0];
                  mode_next      = jsu_pkg::MODE_HBS;
                end else if (is_low) begin
                  mode_next = jsu_pkg::MODE_IDLE;
                end else begin
                  mode_next = jsu_pkg::MODE_BODY;
                end
              end
            end
          end
          jsu_pkg::MODE_HBS: begin
            mode_next = (c == 8'h5C) ? jsu_pkg::MODE_HU : jsu_pkg::MODE_IDLE;
          end
          jsu_pkg::MODE_HU: begin
            if (c == 8'h75) begin
              mode_next        = jsu_pkg::MODE_HEX;
              hex_count_next   = 2'd0;
              hex_accum_next   = 16'd0;
              in_low_unit_next = 1'b1;
            end else begin
              mode_next = jsu_pkg::MODE_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      jsu_pkg::CMD_END: begin
        mode_next = jsu_pkg::MODE_IDLE;
      end
      default: begin
      end
    endcase
  end

  // result set
  always_comb begin
    set_valid = 1'b0;
    set       = '0;
    unique case (item.cmd)
      jsu_pkg::CMD_DATA: begin
        unique case (mode)
          jsu_pkg::MODE_BODY: begin
            set_valid = 1'b1;
            if (c == 8'h22) begin
              set.kind = jsu_pkg::KIND_DONE;
            end else if (c < 8'h20) begin
              set.kind = jsu_pkg::KIND_ERROR;
              set.code = jsu_pkg::ERR_CTRL_CHAR;
            end else if (c == 8'h5C) begin
              set_valid = 1'b0;
            end else begin
              set.bytes[0] = c;
            end
          end
          jsu_pkg::MODE_ESC: begin
            set_valid = 1'b1;
            unique case (c)
              8'h22, 8'h5C, 8'h2F: set.bytes[0] = c;
              8'h62: set.bytes[0] = 8'h08;
              8'h66: set.bytes[0] = 8'h0C;
              8'h6E: set.bytes[0] = 8'h0A;
              8'h72: set.bytes[0] = 8'h0D;
              8'h74: set.bytes[0] = 8'h09;
              8'h75: set_valid = 1'b0;
              default: begin
                set.kind = jsu_pkg::KIND_ERROR;
                set.code = jsu_pkg::ERR_UNKNOWN_ESC;
              end
            endcase
          end
          jsu_pkg::MODE_HEX: begin
            if (!hok) begin
              set_valid = 1'b1;
              set.kind  = jsu_pkg::KIND_ERROR;
              set.code  = jsu_pkg::ERR_BAD_HEX;
            end else if (unit_end) begin
              set_valid = 1'b1;
              if (in_low_unit && !is_low) begin
                set.kind = jsu_pkg::KIND_ERROR;
                set.code = jsu_pkg::ERR_HIGH_NO_LOW;
              end else if (!in_low_unit && is_high) begin
                set_valid = 1'b0;
              end else if (!in_low_unit && is_low) begin
                set.kind = jsu_pkg::KIND_ERROR;
                set.code = jsu_pkg::ERR_LONE_LOW;
              end else begin
                set.bytes    = enc_bytes;
                set.last_idx = enc_last;
              end
            end
          end
          jsu_pkg::MODE_HBS: begin
            if (c != 8'h5C) begin
              set_valid = 1'b1;
              set.kind  = jsu_pkg::KIND_ERROR;
              set.code  = jsu_pkg::ERR_HIGH_ALONE;
            end
          end
          jsu_pkg::MODE_HU: begin
            if (c != 8'h75) begin
              set_valid = 1'b1;
              set.kind  = jsu_pkg::KIND_ERROR;
              set.code  = jsu_pkg::ERR_HIGH_ALONE;
            end
          end
          default: begin
          end
        endcase
      end
      jsu_pkg::CMD_END: begin
        set_valid = (mode != jsu_pkg::MODE_IDLE);
        set.kind  = jsu_pkg::KIND_ERROR;
        unique case (mode)
          jsu_pkg::MODE_BODY: set.code = jsu_pkg::ERR_UNTERM_STR;
          jsu_pkg::MODE_ESC:  set.code = jsu_pkg::ERR_UNTERM_ESC;
          jsu_pkg::MODE_HEX:  set.code = jsu_pkg::ERR_TRUNC_HEX;
          jsu_pkg::MODE_HBS:  set.code = jsu_pkg::ERR_HIGH_ALONE;
          jsu_pkg::MODE_HU:   set.code = jsu_pkg::ERR_HIGH_ALONE;
          default:            set.code = jsu_pkg::ERR_UNTERM_STR;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= jsu_pkg::MODE_IDLE;
      hex_count   <= 2'd0;
      hex_accum   <= 16'd0;
      high_part   <= 10'd0;
      in_low_unit <= 1'b0;
    end else if (fire) begin
      mode        <= mode_next;
      hex_count   <= hex_count_next;
      hex_accum   <= hex_accum_next;
      high_part   <= high_part_next;
      in_low_unit <= in_low_unit_next;
    end
  end

endmodule

>>> src/jsu_out_ser.sv
// ----------------------------------------------------------------------------
// jsu_out_ser
// Result set register; sends one word of the set per cycle while not stalled.
// ----------------------------------------------------------------------------
module jsu_out_ser (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic           set_valid,
  input  jsu_pkg::rset_t set_in,
  output logic           ready,
  output logic           valid,
  input  logic           stall,
  output logic [7:0]     out_byte,
  output logic [1:0]     kind,
  output logic [3:0]     error_code,
  output logic           last
);

  jsu_pkg::rset_t set;
  logic           busy;
  logic [1:0]     idx;
  logic           at_last;

  assign at_last    = (idx == set.last_idx);
  assign ready      = !busy || (!stall && at_last);
  assign valid      = busy;
  assign out_byte   = set.bytes[idx];
  assign kind       = set.kind;
  assign error_code = set.code;
  assign last       = at_last;

  always_ff @(posedge clk) begin
    if (fire && set_valid) begin
      set <= set_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (fire) begin
      busy <= set_valid;
      idx  <= 2'd0;
    end else if (busy && !stall) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

>>> src/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// JSON string body decoder: escapes and \u pairs in, UTF-8 bytes out.
// ----------------------------------------------------------------------------
// Takes one command word per cycle while req_stall is low and sends one
// result word per cycle while res_stall is low. An escape sequence that ends
// in a code point gives one to four result words, sent one after another from
// the result register; a two-entry input buffer keeps taking words meanwhile
// and raises req_stall only when both entries are full. A word waits in the
// input buffer and its results in the result register. The next word is
// decoded in the cycle the last result word of the previous one is taken.
module json_string_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] byte_req,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [3:0] error_code,
  output logic       last
);

  jsu_pkg::item_t wr_item;
  jsu_pkg::item_t rd_item;
  jsu_pkg::rset_t set;
  logic           rd_valid;
  logic           ser_ready;
  logic           fire;
  logic           set_valid;

  assign wr_item.cmd  = cmd;
  assign wr_item.data = byte_req;
  assign fire         = rd_valid && ser_ready;

  jsu_in_buf u_in_buf (
    .clk      (clk),
    .rst      (rst),
    .valid    (req_valid),
    .stall    (req_stall),
    .wr_item  (wr_item),
    .rd_valid (rd_valid),
    .rd_take  (ser_ready),
    .rd_item  (rd_item)
  );

  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (rd_item),
    .set_valid (set_valid),
    .set       (set)
  );

  jsu_out_ser u_out_ser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .set_valid  (set_valid),
    .set_in     (set),
    .ready      (ser_ready),
    .valid      (res_valid),
    .stall      (res_stall),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

endmodule

>>> test/json_string_unescape_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_test
// Self-checking bench for the JSON string body decoder.
// ----------------------------------------------------------------------------
// A short table of directed words comes first. Then random strings follow,
// mostly well formed with random text, escapes, \u units and surrogate pairs,
// and the rest broken in every way the decoder flags. A behavioral decoder in
// the bench predicts the result words, and the monitor compares each accepted
// result word with the oldest prediction. Both handshakes idle and stall at
// random, with one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module json_string_unescape_test;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [3:0] CODE_NONE = 4'd0;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] ESC_CHARS [9] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E,
                                           8'h72, 8'h74, 8'h75};
  localparam int ITEM_TARGET = 410;

  typedef struct packed {
    logic [7:0] b;
    logic [1:0] k;
    logic [3:0] code;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {BY_MODEL, TYPED_NONE, TYPED_ONE} chk_t;

  typedef struct packed {
    logic [1:0] c;
    logic [7:0] d;
    chk_t       chk;
    res_t       r;
  } row_t;

  localparam res_t NO_RES = '0;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic [1:0] cmd;
  logic [7:0] byte_req;
  logic       res_valid;
  logic       res_stall;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [3:0] error_code;
  logic       last;

  res_t  exp_q[$];
  res_t  step_q[$];
  int    idle_pct = 37;
  int    err_count = 0;
  int    items_sent = 0;

  jsu_pkg::mode_t dec_mode = jsu_pkg::MODE_IDLE;
  logic [1:0]  hex_cnt = '0;
  logic [15:0] hex_acc = '0;
  logic [9:0]  hi_bits = '0;
  logic        low_pending = 1'b0;

  row_t dir_tab [25] = '{
    '{jsu_pkg::CMD_DATA,  8'h00, TYPED_NONE, NO_RES},
    '{jsu_pkg::CMD_END,   8'h00, TYPED_NONE, NO_RES},
    '{CMD_SPARE,          8'hFF, TYPED_NONE, NO_RES},
    '{jsu_pkg::CMD_START, 8'h00, TYPED_NONE, NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h20, TYPED_ONE,
      '{8'h20, jsu_pkg::KIND_DATA, CODE_NONE, 1'b1}},
    '{jsu_pkg::CMD_DATA,  8'hFF, TYPED_ONE,
      '{8'hFF, jsu_pkg::KIND_DATA, CODE_NONE, 1'b1}},
    '{jsu_pkg::CMD_START, 8'hFF, TYPED_NONE, NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h5C, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h75, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h44, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h38, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h33, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h44, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h5C, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h75, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h64, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h65, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h30, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h30, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h5C, BY_MODEL,   NO_RES},
    '{jsu_pkg::CMD_END,   8'h00, TYPED_ONE,
      '{8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM_ESC, 1'b1}},
    '{jsu_pkg::CMD_START, 8'h00, TYPED_NONE, NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h1F, TYPED_ONE,
      '{8'h00, jsu_pkg::KIND_ERROR, jsu_pkg::ERR_CTRL_CHAR, 1'b1}},
    '{jsu_pkg::CMD_START, 8'h00, TYPED_NONE, NO_RES},
    '{jsu_pkg::CMD_DATA,  8'h22, TYPED_ONE,
      '{8'h00, jsu_pkg::KIND_DONE, CODE_NONE, 1'b1}}
  };

  json_string_unescape i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .byte_req   (byte_req),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int hex_nibble(input logic [7:0] ch);
    if (ch >= 8'h30 && ch <= 8'h39) return int'(ch - 8'h30);
    if (ch >= 8'h61 && ch <= 8'h66) return int'(ch - 8'h61) + 10;
    if (ch >= 8'h41 && ch <= 8'h46) return int'(ch - 8'h41) + 10;
    return -1;
  endfunction

  task automatic push_res(input logic [7:0] b, input logic [1:0] k, input logic [3:0] code);
    res_t r;
    r = '{b, k, code, 1'b0};
    step_q = {step_q, r};
  endtask

  task automatic fail(input logic [3:0] code);
    dec_mode = jsu_pkg::MODE_IDLE;
    push_res(8'h00, jsu_pkg::KIND_ERROR, code);
  endtask

  task automatic put_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_res(cp[7:0], jsu_pkg::KIND_DATA, CODE_NONE);
    end else if (cp < 21'h800) begin
      push_res(8'hC0 | cp[10:6], jsu_pkg::KIND_DATA, CODE_NONE);
      push_res(8'h80 | cp[5:0], jsu_pkg::KIND_DATA, CODE_NONE);
    end else if (cp < 21'h10000) begin
      push_res(8'hE0 | cp[15:12], jsu_pkg::KIND_DATA, CODE_NONE);
      push_res(8'h80 | cp[11:6], jsu_pkg::KIND_DATA, CODE_NONE);
      push_res(8'h80 | cp[5:0], jsu_pkg::KIND_DATA, CODE_NONE);
    end else begin
      push_res(8'hF0 | cp[20:18], jsu_pkg::KIND_DATA, CODE_NONE);
      push_res(8'h80 | cp[17:12], jsu_pkg::KIND_DATA, CODE_NONE);
      push_res(8'h80 | cp[11:6], jsu_pkg::KIND_DATA, CODE_NONE);
      push_res(8'h80 | cp[5:0], jsu_pkg::KIND_DATA, CODE_NONE);
    end
  endtask

  task automatic decode_word(input logic [1:0] c, input logic [7:0] d);
    int          nib;
    logic [15:0] unit;
    step_q.delete();
    if (c == jsu_pkg::CMD_START) begin
      dec_mode    = jsu_pkg::MODE_BODY;
      hex_cnt     = '0;
      hex_acc     = '0;
      hi_bits     = '0;
      low_pending = 1'b0;
    end else if (c == jsu_pkg::CMD_DATA) begin
      case (dec_mode)
        jsu_pkg::MODE_BODY: begin
          if (d == CH_QUOTE) begin
            dec_mode = jsu_pkg::MODE_IDLE;
            push_res(8'h00, jsu_pkg::KIND_DONE, CODE_NONE);
          end else if (d < 8'h20) begin
            fail(jsu_pkg::ERR_CTRL_CHAR);
          end else if (d == CH_BSLASH) begin
            dec_mode = jsu_pkg::MODE_ESC;
          end else begin
            push_res(d, jsu_pkg::KIND_DATA, CODE_NONE);
          end
        end
        jsu_pkg::MODE_ESC: begin
          dec_mode = jsu_pkg::MODE_BODY;
          case (d)
            8'h22, 8'h5C, 8'h2F: push_res(d, jsu_pkg::KIND_DATA, CODE_NONE);
            8'h62: push_res(8'h08, jsu_pkg::KIND_DATA, CODE_NONE);
            8'h66: push_res(8'h0C, jsu_pkg::KIND_DATA, CODE_NONE);
            8'h6E: push_res(8'h0A, jsu_pkg::KIND_DATA, CODE_NONE);
            8'h72: push_res(8'h0D, jsu_pkg::KIND_DATA, CODE_NONE);
            8'h74: push_res(8'h09, jsu_pkg::KIND_DATA, CODE_NONE);
            CH_U: begin
              dec_mode    = jsu_pkg::MODE_HEX;
              hex_cnt     = '0;
              hex_acc     = '0;
              low_pending = 1'b0;
            end
            default: fail(jsu_pkg::ERR_UNKNOWN_ESC);
          endcase
        end
        jsu_pkg::MODE_HEX: begin
          nib = hex_nibble(d);
          if (nib < 0) begin
            fail(jsu_pkg::ERR_BAD_HEX);
          end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            if (hex_cnt == 2'd3) begin
              hex_cnt = '0;
              unit = hex_acc;
              if (low_pending) begin
                if (unit < 16'hDC00 || unit > 16'hDFFF) begin
                  fail(jsu_pkg::ERR_HIGH_NO_LOW);
                end else begin
                  dec_mode = jsu_pkg::MODE_BODY;
                  put_code_point(21'h10000 + {1'b0, hi_bits, 10'd0} +
                                 {5'd0, unit - 16'hDC00});
                end
              end else if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                hi_bits  = unit[9:0];
                dec_mode = jsu_pkg::MODE_HBS;
              end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                fail(jsu_pkg::ERR_LONE_LOW);
              end else begin
                dec_mode = jsu_pkg::MODE_BODY;
                put_code_point({5'd0, unit});
              end
            end else begin
              hex_cnt = hex_cnt + 2'd1;
            end
          end
        end
        jsu_pkg::MODE_HBS: begin
          if (d != CH_BSLASH) fail(jsu_pkg::ERR_HIGH_ALONE);
          else dec_mode = jsu_pkg::MODE_HU;
        end
        jsu_pkg::MODE_HU: begin
          if (d != CH_U) begin
            fail(jsu_pkg::ERR_HIGH_ALONE);
          end else begin
            dec_mode    = jsu_pkg::MODE_HEX;
            hex_cnt     = '0;
            hex_acc     = '0;
            low_pending = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (c == jsu_pkg::CMD_END) begin
      case (dec_mode)
        jsu_pkg::MODE_BODY: fail(jsu_pkg::ERR_UNTERM_STR);
        jsu_pkg::MODE_ESC:  fail(jsu_pkg::ERR_UNTERM_ESC);
        jsu_pkg::MODE_HEX:  fail(jsu_pkg::ERR_TRUNC_HEX);
        jsu_pkg::MODE_HBS, jsu_pkg::MODE_HU: fail(jsu_pkg::ERR_HIGH_ALONE);
        default: ;
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endtask

  // Enter and leave at a falling edge; hold the word until it is taken.
  task automatic send_word(input row_t w);
    while ($urandom_range(99) < idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    cmd       = w.c;
    byte_req  = w.d;
    do @(posedge clk); while (req_stall);
    decode_word(w.c, w.d);
    if (w.chk == BY_MODEL) begin
      foreach (step_q[j]) exp_q = {exp_q, step_q[j]};
    end else if (w.chk == TYPED_ONE) begin
      exp_q = {exp_q, w.r};
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put(input logic [1:0] c, input logic [7:0] d);
    row_t w;
    w = '{c, d, BY_MODEL, NO_RES};
    send_word(w);
  endtask

  task automatic send_u_esc(input logic [15:0] u, input int ndig);
    logic [3:0] n;
    put(jsu_pkg::CMD_DATA, CH_BSLASH);
    put(jsu_pkg::CMD_DATA, CH_U);
    for (int i = 0; i < ndig; i++) begin
      n = u[15 - 4 * i -: 4];
      if (n < 4'd10) put(jsu_pkg::CMD_DATA, 8'h30 + n);
      else if ($urandom_range(1)) put(jsu_pkg::CMD_DATA, 8'h61 + n - 8'd10);
      else put(jsu_pkg::CMD_DATA, 8'h41 + n - 8'd10);
    end
  endtask

  task automatic send_piece();
    int          sel;
    logic [7:0]  d;
    logic [15:0] u;
    sel = $urandom_range(99);
    if (sel < 55) begin
      do d = 8'($urandom_range(8'h20, 8'hFF)); while (d == CH_QUOTE || d == CH_BSLASH);
      put(jsu_pkg::CMD_DATA, d);
    end else if (sel < 70) begin
      put(jsu_pkg::CMD_DATA, CH_BSLASH);
      put(jsu_pkg::CMD_DATA, ESC_CHARS[$urandom_range(7)]);
    end else if (sel < 88) begin
      case ($urandom_range(2))
        0: u = 16'($urandom_range(16'h7F));
        1: u = 16'($urandom_range(16'h80, 16'h7FF));
        default: do u = 16'($urandom_range(16'h800, 16'hFFFF));
                 while (u >= 16'hD800 && u <= 16'hDFFF);
      endcase
      send_u_esc(u, 4);
    end else begin
      send_u_esc(16'hD800 + 16'($urandom_range(1023)), 4);
      send_u_esc(16'hDC00 + 16'($urandom_range(1023)), 4);
    end
  endtask

  task automatic send_string();
    int          sel;
    bit          hit;
    logic [7:0]  d;
    logic [15:0] u;
    put(jsu_pkg::CMD_START, 8'($urandom_range(255)));
    repeat ($urandom_range(1, 8)) send_piece();
    sel = $urandom_range(99);
    if (sel < 66) begin
      put(jsu_pkg::CMD_DATA, CH_QUOTE);
    end else if (sel < 71) begin
      put(jsu_pkg::CMD_END, 8'($urandom_range(255)));
    end else if (sel < 76) begin
      put(jsu_pkg::CMD_DATA, 8'($urandom_range(8'h1F)));
    end else if (sel < 80) begin
      do begin
        d = 8'($urandom_range(255));
        hit = 1'b0;
        foreach (ESC_CHARS[j]) if (ESC_CHARS[j] == d) hit = 1'b1;
      end while (hit);
      put(jsu_pkg::CMD_DATA, CH_BSLASH);
      put(jsu_pkg::CMD_DATA, d);
    end else if (sel < 84) begin
      do d = 8'($urandom_range(255)); while (hex_nibble(d) >= 0);
      send_u_esc(16'($urandom_range(16'hFFFF)), $urandom_range(3));
      put(jsu_pkg::CMD_DATA, d);
    end else if (sel < 87) begin
      send_u_esc(16'($urandom_range(16'hFFFF)), $urandom_range(3));
      put(jsu_pkg::CMD_END, 8'($urandom_range(255)));
    end else if (sel < 89) begin
      put(jsu_pkg::CMD_DATA, CH_BSLASH);
      put(jsu_pkg::CMD_END, 8'($urandom_range(255)));
    end else if (sel < 94) begin
      send_u_esc(16'hD800 + 16'($urandom_range(1023)), 4);
      case ($urandom_range(4))
        0: begin
          d = 8'($urandom_range(255));
          put(jsu_pkg::CMD_DATA, (d == CH_BSLASH) ? CH_QUOTE : d);
        end
        1: begin
          d = 8'($urandom_range(255));
          put(jsu_pkg::CMD_DATA, CH_BSLASH);
          put(jsu_pkg::CMD_DATA, (d == CH_U) ? CH_QUOTE : d);
        end
        2: put(jsu_pkg::CMD_END, 8'($urandom_range(255)));
        3: begin
          put(jsu_pkg::CMD_DATA, CH_BSLASH);
          put(jsu_pkg::CMD_END, 8'($urandom_range(255)));
        end
        default: begin
          do u = 16'($urandom_range(16'hFFFF)); while (u >= 16'hDC00 && u <= 16'hDFFF);
          send_u_esc(u, 4);
        end
      endcase
    end else if (sel < 97) begin
      send_u_esc(16'hDC00 + 16'($urandom_range(1023)), 4);
    end else if (sel < 98) begin
      put(CMD_SPARE, 8'($urandom_range(255)));
      put(jsu_pkg::CMD_DATA, CH_QUOTE);
    end
    // otherwise leave it open: the next start drops it
  endtask

  task automatic drain();
    req_valid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      res_stall = ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      got = '{out_byte, kind, error_code, last};
      if (exp_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected word: byte %h kind %0d code %0d last %b",
                   got.b, got.k, got.code, got.last);
      end else begin
        want = exp_q.pop_front();
        if (got.b !== want.b || got.k !== want.k || got.code !== want.code ||
            got.last !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected byte %h kind %0d code %0d last %b, ",
                     want.b, want.k, want.code, want.last,
                     "got byte %h kind %0d code %0d last %b",
                     got.b, got.k, got.code, got.last);
        end
      end
    end
  end

  initial begin : stimulus
    int row_no;
    int string_no;
    rst       = 1'b1;
    req_valid = 1'b0;
    cmd       = jsu_pkg::CMD_START;
    byte_req  = 8'h00;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    for (row_no = 0; row_no < 25; row_no++) send_word(dir_tab[row_no]);
    drain();
    string_no = 0;
    while (items_sent < ITEM_TARGET) begin
      idle_pct = (string_no >= 10 && string_no < 20) ? 0 : 37;
      if ($urandom_range(99) < 15)
        send_word('{2'($urandom_range(1, 3)), 8'($urandom_range(255)), BY_MODEL, NO_RES});
      send_string();
      if (string_no % 12 == 11) drain();
      string_no++;
    end
    drain();
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
